FILE: rtl/core/der_ecdsa_signature_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// der_ecdsa_signature_decoder_unit_defines
// assertion macros shared by the decoder rtl
// ----------------------------------------------------------------------------
`ifndef DER_ECDSA_SIGNATURE_DECODER_UNIT_DEFINES_SVH
`define DER_ECDSA_SIGNATURE_DECODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// plain property, sampled on clk_i, off during reset
`define DESD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// same-cycle implication
`define DESD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define DESD_ASSERT(lbl, prop, msg)
`define DESD_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/desd_pkg.sv
// ----------------------------------------------------------------------------
// desd_pkg
// shared types and constants of the der ecdsa signature decoder
// ----------------------------------------------------------------------------
package desd_pkg;

  // integer sizing
  localparam int INT_BYTES = 32;
  localparam int VAL_BITS  = 256;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = VAL_BITS / WORD_BITS;
  localparam int IDX_W     = $clog2(NUM_WORDS);
  localparam int CNT_W     = $clog2(2 * NUM_WORDS);
  localparam int SC_W      = $clog2(INT_BYTES + 2);

  // der encoding bytes
  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;
  localparam logic [7:0] LEN_LONG     = 8'h80;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;

  // job queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    FAULT_NONE    = 3'd0,
    FAULT_SHORT   = 3'd1,
    FAULT_SEQ_TAG = 3'd2,
    FAULT_SEQ_LEN = 3'd3,
    FAULT_R_TAG   = 3'd4,
    FAULT_R_LEN   = 3'd5,
    FAULT_S_TAG   = 3'd6,
    FAULT_S_LEN   = 3'd7
  } desd_fault_e;

  // one decoded signature waiting for output
  typedef struct packed {
    desd_fault_e          code;
    logic [VAL_BITS-1:0]  r_val;
    logic [VAL_BITS-1:0]  s_val;
  } desd_job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } desd_qstat_t;

endpackage

FILE: rtl/core/desd_if.sv
// ----------------------------------------------------------------------------
// desd_if
// valid/ready stream interfaces for byte input and word output
// ----------------------------------------------------------------------------
interface desd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface desd_out_if;
  import desd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 decode_ok;
  logic [2:0]           fault_code;
  logic                 which_integer;
  logic [IDX_W-1:0]     word_index;
  logic [WORD_BITS-1:0] word_value;
  logic                 last_word;

  modport source (output valid, output decode_ok, output fault_code, output which_integer,
                  output word_index, output word_value, output last_word, input ready);
  modport sink   (input valid, input decode_ok, input fault_code, input which_integer,
                  input word_index, input word_value, input last_word, output ready);
endinterface

FILE: rtl/core/desd_front.sv
// ----------------------------------------------------------------------------
// desd_front
// byte parser: walks the der structure one item a cycle while the job queue is
// not full, pushes a job on the final byte
// ----------------------------------------------------------------------------
module desd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  desd_in_if.sink              in_i,
  input  desd_pkg::desd_qstat_t qstat_i,
  output logic                 push_o,
  output desd_pkg::desd_job_t  job_o
);
  import desd_pkg::*;

  typedef enum logic [3:0] {
    PH_SEQ_TAG = 4'd0,
    PH_SEQ_LEN = 4'd1,
    PH_R_TAG   = 4'd2,
    PH_R_LEN   = 4'd3,
    PH_R_BODY  = 4'd4,
    PH_S_TAG   = 4'd5,
    PH_S_LEN   = 4'd6,
    PH_S_BODY  = 4'd7,
    PH_DONE    = 4'd8,
    PH_DRAIN   = 4'd9
  } phase_e;

  phase_e              ph_q, ph_n;
  logic [7:0]          seen_q, seen_n;
  logic [6:0]          slen_q, slen_n;
  logic [7:0]          left_q, left_n;
  logic                lz_q, lz_n;
  logic [SC_W-1:0]     sc_q, sc_n;
  logic [VAL_BITS-1:0] r_q, r_n, s_q, s_n;
  desd_fault_e         ff_q, ff_n;

  logic                accept;
  logic [7:0]          b;
  logic [7:0]          expect_len;
  logic [8:0]          int_end;
  logic [SC_W-1:0]     sc_inc;
  logic [7:0]          expect_n;
  desd_fault_e         code;

  assign in_i.ready = !qstat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign expect_len = 8'(slen_q) + 8'd2;
  assign int_end    = 9'(seen_q) + 9'd1 + 9'(b);
  assign sc_inc     = (sc_q <= SC_W'(INT_BYTES)) ? sc_q + SC_W'(1) : sc_q;

  // one parse step on the current byte
  always_comb begin
    ph_n   = ph_q;
    slen_n = slen_q;
    left_n = left_q;
    lz_n   = lz_q;
    sc_n   = sc_q;
    r_n    = r_q;
    s_n    = s_q;
    ff_n   = ff_q;
    seen_n = (seen_q != 8'hFF) ? seen_q + 8'd1 : seen_q;

    // byte past the declared sequence end
    if (ph_q >= PH_R_TAG && ph_q <= PH_DONE && seen_q >= expect_len) begin
      ff_n = FAULT_SEQ_LEN;
      ph_n = PH_DRAIN;
    end else begin
      case (ph_q)
        PH_SEQ_TAG: begin
          if (b != TAG_SEQUENCE) begin
            ff_n = FAULT_SEQ_TAG;
            ph_n = PH_DRAIN;
          end else begin
            ph_n = PH_SEQ_LEN;
          end
        end
        PH_SEQ_LEN: begin
          if ((b & LEN_LONG) != BYTE_ZERO) begin
            ff_n = FAULT_SEQ_LEN;
            ph_n = PH_DRAIN;
          end else begin
            slen_n = b[6:0];
            ph_n   = PH_R_TAG;
          end
        end
        PH_R_TAG, PH_S_TAG: begin
          if (b != TAG_INTEGER) begin
            ff_n = (ph_q == PH_R_TAG) ? FAULT_R_TAG : FAULT_S_TAG;
            ph_n = PH_DRAIN;
          end else if (ph_q == PH_R_TAG) begin
            r_n  = '0;
            ph_n = PH_R_LEN;
          end else begin
            s_n  = '0;
            ph_n = PH_S_LEN;
          end
        end
        PH_R_LEN: begin
          if (b == BYTE_ZERO || int_end > 9'(expect_len)) begin
            ff_n = FAULT_R_LEN;
            ph_n = PH_DRAIN;
          end else begin
            left_n = b;
            lz_n   = 1'b1;
            sc_n   = '0;
            ph_n   = PH_R_BODY;
          end
        end
        PH_S_LEN: begin
          if (b == BYTE_ZERO || int_end != 9'(expect_len)) begin
            ff_n = FAULT_S_LEN;
            ph_n = PH_DRAIN;
          end else begin
            left_n = b;
            lz_n   = 1'b1;
            sc_n   = '0;
            ph_n   = PH_S_BODY;
          end
        end
        PH_R_BODY, PH_S_BODY: begin
          if (!(lz_q && b == BYTE_ZERO) && sc_inc > SC_W'(INT_BYTES)) begin
            // too many significant bytes
            lz_n = 1'b0;
            sc_n = sc_inc;
            ff_n = (ph_q == PH_R_BODY) ? FAULT_R_LEN : FAULT_S_LEN;
            ph_n = PH_DRAIN;
          end else begin
            if (!(lz_q && b == BYTE_ZERO)) begin
              lz_n = 1'b0;
              sc_n = sc_inc;
              if (ph_q == PH_R_BODY) r_n = {r_q[VAL_BITS-9:0], b};
              else                   s_n = {s_q[VAL_BITS-9:0], b};
            end
            left_n = left_q - 8'd1;
            if (left_n == 8'd0) ph_n = (ph_q == PH_R_BODY) ? PH_S_TAG : PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // outcome of a final byte, first failing check wins
  assign expect_n = 8'(slen_n) + 8'd2;

  always_comb begin
    if (seen_q == 8'd0) begin
      code = FAULT_SHORT;
    end else if (ff_n == FAULT_SEQ_TAG || ff_n == FAULT_SEQ_LEN) begin
      code = ff_n;
    end else if (seen_n != expect_n) begin
      code = FAULT_SEQ_LEN;
    end else if (ff_n != FAULT_NONE) begin
      code = ff_n;
    end else begin
      case (ph_n)
        PH_R_TAG:             code = FAULT_R_TAG;
        PH_R_LEN, PH_R_BODY:  code = FAULT_R_LEN;
        PH_S_TAG:             code = FAULT_S_TAG;
        PH_S_LEN, PH_S_BODY:  code = FAULT_S_LEN;
        PH_DONE:              code = FAULT_NONE;
        default:              code = FAULT_SEQ_LEN;
      endcase
    end
  end

  assign push_o      = accept && in_i.final_byte;
  assign job_o.code  = code;
  assign job_o.r_val = r_n;
  assign job_o.s_val = s_n;

  // parser state, back to start after every final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_SEQ_TAG;
      seen_q <= '0;
      slen_q <= '0;
      left_q <= '0;
      lz_q   <= 1'b1;
      sc_q   <= '0;
      ff_q   <= FAULT_NONE;
    end else if (accept) begin
      if (in_i.final_byte) begin
        ph_q   <= PH_SEQ_TAG;
        seen_q <= '0;
        slen_q <= '0;
        left_q <= '0;
        lz_q   <= 1'b1;
        sc_q   <= '0;
        ff_q   <= FAULT_NONE;
      end else begin
        ph_q   <= ph_n;
        seen_q <= seen_n;
        slen_q <= slen_n;
        left_q <= left_n;
        lz_q   <= lz_n;
        sc_q   <= sc_n;
        ff_q   <= ff_n;
      end
    end
  end

  // integer accumulators, cleared on each integer tag
  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_q <= r_n;
      s_q <= s_n;
    end
  end

endmodule

FILE: rtl/core/desd_queue.sv
// ----------------------------------------------------------------------------
// desd_queue
// small fifo of decoded jobs between parser and word sequencer
// ----------------------------------------------------------------------------
`include "der_ecdsa_signature_decoder_unit_defines.svh"

module desd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  desd_pkg::desd_job_t   job_i,
  input  logic                  pop_i,
  output desd_pkg::desd_job_t   head_o,
  output desd_pkg::desd_qstat_t stat_o
);
  import desd_pkg::*;

  desd_job_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    ptr_next = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_next(wr_q);
      if (pop_i)  rd_q <= ptr_next(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + QCNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  `DESD_ASSERT_IMP(a_no_push_full, push_i, !stat_o.full, "push into full job queue")
  `DESD_ASSERT_IMP(a_no_pop_empty, pop_i, !stat_o.empty, "pop from empty job queue")
  `DESD_ASSERT(a_cnt_range, cnt_q <= QCNT_W'(QDEPTH), "job queue count out of range")

endmodule

FILE: rtl/core/desd_back.sv
// ----------------------------------------------------------------------------
// desd_back
// word sequencer: turns each job into one fault item or eight word items
// ----------------------------------------------------------------------------
`include "der_ecdsa_signature_decoder_unit_defines.svh"

module desd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  desd_pkg::desd_job_t   head_i,
  input  desd_pkg::desd_qstat_t qstat_i,
  output logic                  pop_o,
  desd_out_if.source            out_o
);
  import desd_pkg::*;

  logic                 valid_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 ok_q;
  desd_fault_e          code_q;
  logic                 which_q;
  logic [IDX_W-1:0]     idx_q;
  logic [WORD_BITS-1:0] value_q;
  logic                 last_q;

  logic                 load;
  logic                 head_valid;
  logic                 is_fault;
  logic [IDX_W-1:0]     idx;
  logic [VAL_BITS-1:0]  sel_val;
  logic [WORD_BITS-1:0] word;

  assign head_valid = !qstat_i.empty;
  assign load       = !valid_q || out_o.ready;
  assign is_fault   = (head_i.code != FAULT_NONE);
  assign idx        = cnt_q[IDX_W-1:0];
  assign sel_val    = cnt_q[CNT_W-1] ? head_i.s_val : head_i.r_val;
  // word 0 is the most significant
  assign word       = sel_val[(NUM_WORDS - 1 - int'(idx)) * WORD_BITS +: WORD_BITS];
  assign pop_o      = load && head_valid && (is_fault || cnt_q == CNT_W'(2 * NUM_WORDS - 1));

  // output valid and word counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (load) begin
      valid_q <= head_valid;
      if (pop_o)           cnt_q <= '0;
      else if (head_valid) cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load && head_valid) begin
      if (is_fault) begin
        ok_q    <= 1'b0;
        code_q  <= head_i.code;
        which_q <= 1'b0;
        idx_q   <= '0;
        value_q <= '0;
        last_q  <= 1'b1;
      end else begin
        ok_q    <= 1'b1;
        code_q  <= FAULT_NONE;
        which_q <= cnt_q[CNT_W-1];
        idx_q   <= idx;
        value_q <= word;
        last_q  <= (cnt_q == CNT_W'(2 * NUM_WORDS - 1));
      end
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.decode_ok     = ok_q;
  assign out_o.fault_code    = code_q;
  assign out_o.which_integer = which_q;
  assign out_o.word_index    = idx_q;
  assign out_o.word_value    = value_q;
  assign out_o.last_word     = last_q;

  `DESD_ASSERT_IMP(a_fault_single, valid_q && !ok_q, last_q && value_q == '0,
                   "fault item must be a single zero last item")
  `DESD_ASSERT_IMP(a_cnt_has_job, cnt_q != '0, head_valid,
                   "word counter running without a job")

endmodule

FILE: rtl/core/der_ecdsa_signature_decoder_unit.sv
// ----------------------------------------------------------------------------
// der_ecdsa_signature_decoder_unit
// decodes a der ecdsa signature byte stream into r and s words or a fault
// ----------------------------------------------------------------------------
//  channel  dir  payload                                           accept
//  in_i     in   data_byte[7:0], final_byte                        valid & ready
//  out_o    out  decode_ok, fault_code[2:0], which_integer,        valid & ready
//                word_index[1:0], word_value[63:0], last_word
//
//  one byte item is parsed per cycle; the parser holds state only between bytes
//  a final byte pushes a job into a two-entry queue, from which words leave
//  at one item per cycle: one item for a fault, eight for a good signature
//  input stalls only while the job queue is full; output stalls hold the register
//  reset clears parser, queue and output valid at once, no clearing pass
// ----------------------------------------------------------------------------
module der_ecdsa_signature_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  desd_in_if.sink     in_i,
  desd_out_if.source  out_o
);
  import desd_pkg::*;

  logic        push;
  logic        pop;
  desd_job_t   job;
  desd_job_t   head;
  desd_qstat_t qstat;

  // byte parser
  desd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .job_o   (job)
  );

  // job queue
  desd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  // word sequencer
  desd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
